@@ hdl/kvtp_pkg.sv @@
// ----------------------------------------------------------------------------
// kvtp_pkg
// shared types and codes of the kv token tier placement unit
// ----------------------------------------------------------------------------
package kvtp_pkg;

    localparam int Q_W = 17;
    localparam logic [Q_W-1:0] Q_ONE = 17'h10000;

    localparam logic [3:0] ACT_SINK      = 4'd0;
    localparam logic [3:0] ACT_WINDOW    = 4'd1;
    localparam logic [3:0] ACT_RING      = 4'd2;
    localparam logic [3:0] ACT_HEAVY_INS = 4'd3;
    localparam logic [3:0] ACT_HEAVY_REP = 4'd4;
    localparam logic [3:0] ACT_DEMOTE    = 4'd5;
    localparam logic [3:0] ACT_WAIT      = 4'd6;
    localparam logic [3:0] ACT_FLUSH     = 4'd7;
    localparam logic [3:0] ACT_SCORE     = 4'd8;

    localparam logic [2:0] CFG_SINK_SLOTS   = 3'd0;
    localparam logic [2:0] CFG_WINDOW_SLOTS = 3'd1;
    localparam logic [2:0] CFG_HEAVY_CAP    = 3'd2;
    localparam logic [2:0] CFG_HEAVY_RATIO  = 3'd3;
    localparam logic [2:0] CFG_DECAY        = 3'd4;
    localparam logic [2:0] CFG_REFRESH      = 3'd5;
    localparam logic [2:0] CFG_BLOCK_SEL    = 3'd6;

    typedef struct packed {
        logic [3:0]  action;
        logic [31:0] token_ref;
        logic [9:0]  slot_index;
        logic [31:0] block_number;
        logic [31:0] token_score;
        logic [31:0] threshold_used;
    } result_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_FB_RD,
        S_FB_CALC,
        S_FB_SCAN,
        S_AP_RD,
        S_AP_DEC,
        S_EV_RD,
        S_EV_GET,
        S_THR,
        S_KTH_SCAN,
        S_KTH_STEP,
        S_ROUTE,
        S_MIN_SCAN,
        S_MIN_DONE,
        S_EMIT
    } state_t;

endpackage

@@ hdl/kvtp_req_if.sv @@
// ----------------------------------------------------------------------------
// kvtp_req_if
// request channel: append or score feedback
// ----------------------------------------------------------------------------
interface kvtp_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] fb_token;
    logic [16:0] fb_weight;

    modport source (output valid, output mode, output fb_token, output fb_weight,
                    input ready);
    modport sink (input valid, input mode, input fb_token, input fb_weight,
                  output ready);
endinterface

@@ hdl/kvtp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// kvtp_rsp_if
// result channel: placement actions
// ----------------------------------------------------------------------------
interface kvtp_rsp_if;
    logic        valid;
    logic        ready;
    logic [3:0]  action;
    logic [31:0] token_ref;
    logic [9:0]  slot_index;
    logic [31:0] block_number;
    logic [31:0] token_score;
    logic [31:0] threshold_used;
    logic        last;

    modport source (output valid, output action, output token_ref, output slot_index,
                    output block_number, output token_score, output threshold_used,
                    output last, input ready);
    modport sink (input valid, input action, input token_ref, input slot_index,
                  input block_number, input token_score, input threshold_used,
                  input last, output ready);
endinterface

@@ hdl/kv_token_tier_placement_unit.sv @@
// ----------------------------------------------------------------------------
// kv_token_tier_placement_unit
// placement controller of a tiered key/value cache with heavy hitter eviction
// ----------------------------------------------------------------------------
// One request at a time; ready is high only while idle. After reset a clearing
// pass writes every word of the score memory before the first request.
// Feedback adds a scan of the heavy table when the token is in range and the
// table is not empty. Append to a sink or window slot needs no scan. Append
// with eviction adds the min search over the heavy table when it runs, plus
// a threshold refresh of up to 32 passes over the single read port of the
// score memory. Results then go out on the result channel in order, each
// held until rsp.ready is high.
module kv_token_tier_placement_unit #(
    parameter int MAX_TOKENS = 4096,
    parameter int MAX_HEAVY  = 256,
    parameter int MAX_WINDOW = 1024,
    parameter int MAX_SINKS  = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    kvtp_req_if.sink    req,
    kvtp_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    import kvtp_pkg::*;

    localparam int TA_W = $clog2(MAX_TOKENS);
    localparam int TC_W = TA_W + 1;
    localparam int HA_W = (MAX_HEAVY > 1) ? $clog2(MAX_HEAVY) : 1;
    localparam int HU_W = $clog2(MAX_HEAVY + 1);
    localparam int KP_W = Q_W + TC_W;
    localparam logic [6:0]      SINK_CAP = (MAX_SINKS > 127) ? 7'd127 : 7'(MAX_SINKS);
    localparam logic [10:0]     WIN_CAP  = (MAX_WINDOW > 2047) ? 11'd2047 : 11'(MAX_WINDOW);
    localparam logic [8:0]      HVY_CAP  = (MAX_HEAVY > 511) ? 9'd511 : 9'(MAX_HEAVY);
    localparam logic [TC_W-1:0] TOK_LIM  = TC_W'(MAX_TOKENS);

    state_t state_reg, state_next;

    logic [6:0]  sink_slots_reg;
    logic [10:0] window_slots_reg;
    logic [8:0]  heavy_cap_reg;
    logic [16:0] heavy_ratio_reg;
    logic [16:0] decay_reg;
    logic [15:0] refresh_reg;
    logic        block_sel_reg;

    logic [TC_W-1:0] clr_cnt_reg;
    logic [6:0]      sink_used_reg;
    logic [10:0]     window_used_reg;
    logic [10:0]     ring_head_reg;
    logic [HU_W-1:0] heavy_used_reg;
    logic [5:0]      waiting_used_reg;
    logic [31:0]     blocks_reg;
    logic [31:0]     tokens_reg;
    logic [31:0]     held_reg;
    logic            stamp_valid_reg;
    logic [31:0]     stamp_reg;

    logic [31:0]     tok_reg;
    logic [16:0]     wgt_reg;
    logic            in_rng_reg;
    logic [31:0]     new_sc_reg;
    logic [31:0]     ev_id_reg;
    logic [31:0]     ev_sc_reg;
    logic [9:0]      ring_slot_reg;

    logic [31:0]     lo_reg, hi_reg;
    logic [TC_W-1:0] k_reg, cnt_reg, scan_reg, end_reg;
    logic            pend_reg;
    logic [HU_W-1:0] hscan_reg;
    logic [HA_W-1:0] hpaddr_reg;
    logic [31:0]     ms_reg, mid_reg;
    logic [HA_W-1:0] mi_reg;
    logic            mfirst_reg;

    result_t         rbuf_reg [4];
    logic [2:0]      rcnt_reg;
    logic [1:0]      ridx_reg;

    logic            s_we, s_re;
    logic [TA_W-1:0] s_waddr, s_raddr;
    logic [31:0]     s_wdata, s_rdata;
    logic            h_we, h_we_sc, h_re;
    logic [HA_W-1:0] h_waddr, h_raddr;
    logic [31:0]     h_wid, h_wsc, h_rid, h_rsc;

    logic [6:0]      eff_sinks;
    logic [10:0]     eff_window;
    logic [8:0]      eff_heavy;
    logic [5:0]      blk_size, wnext;
    logic            flush;
    logic            thr_le, refresh_due, span_ok;
    logic [31:0]     end_raw;
    logic [TC_W-1:0] end_c, nm1;
    logic [16:0]     qv, dv;
    logic [KP_W-1:0] kprod;
    logic [31:0]     mid, lo_n, hi_n;
    logic            kgt, kth_issue, h_issue, last;
    logic [48:0]     fprod;
    logic [33:0]     fsum;
    logic [31:0]     fb_res;
    logic            ev_ok, is_sink, is_window, ins_ok, rep_ok;
    logic [10:0]     head_fix, head_inc;
    result_t         ring_res, wait_res, flush_res, cur_res;

    kvtp_ram #(.DEPTH(MAX_TOKENS), .DW(32), .AW(TA_W)) u_score (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .re(s_re), .raddr(s_raddr), .rdata(s_rdata)
    );

    kvtp_ram #(.DEPTH(MAX_HEAVY), .DW(32), .AW(HA_W)) u_heavy_id (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wid),
        .re(h_re), .raddr(h_raddr), .rdata(h_rid)
    );

    kvtp_ram #(.DEPTH(MAX_HEAVY), .DW(32), .AW(HA_W)) u_heavy_sc (
        .clk(clk), .we(h_we_sc), .waddr(h_waddr), .wdata(h_wsc),
        .re(h_re), .raddr(h_raddr), .rdata(h_rsc)
    );

    // effective register values and shared arithmetic
    always_comb
    begin
        eff_sinks   = (sink_slots_reg > SINK_CAP) ? SINK_CAP : sink_slots_reg;
        eff_window  = (window_slots_reg == 11'd0) ? 11'd1 :
                      ((window_slots_reg > WIN_CAP) ? WIN_CAP : window_slots_reg);
        eff_heavy   = (heavy_cap_reg == 9'd0) ? 9'd1 :
                      ((heavy_cap_reg > HVY_CAP) ? HVY_CAP : heavy_cap_reg);
        blk_size    = block_sel_reg ? 6'd32 : 6'd16;
        wnext       = waiting_used_reg + 6'd1;
        flush       = (wnext >= blk_size);
        thr_le      = ({1'b0, tokens_reg} <= (33'(eff_window) + 33'(eff_sinks)));
        refresh_due = !stamp_valid_reg || ((tokens_reg - stamp_reg) >= 32'(refresh_reg));
        end_raw     = tokens_reg - 32'(eff_window);
        end_c       = (end_raw > 32'(MAX_TOKENS)) ? TOK_LIM : end_raw[TC_W-1:0];
        span_ok     = (end_c > TC_W'(eff_sinks));
        qv          = Q_ONE - ((heavy_ratio_reg > Q_ONE) ? Q_ONE : heavy_ratio_reg);
        nm1         = end_c - TC_W'(eff_sinks) - TC_W'(1);
        kprod       = KP_W'(qv) * KP_W'(nm1);
        mid         = lo_reg + ((hi_reg - lo_reg) >> 1);
        kgt         = (cnt_reg > k_reg);
        lo_n        = kgt ? lo_reg : (mid + 32'd1);
        hi_n        = kgt ? mid : hi_reg;
        kth_issue   = (scan_reg < end_reg);
        h_issue     = (hscan_reg < heavy_used_reg);
        dv          = (decay_reg > Q_ONE) ? Q_ONE : decay_reg;
        fprod       = 49'(dv) * 49'(s_rdata);
        fsum        = 34'(fprod[48:16]) + 34'(wgt_reg);
        fb_res      = (fsum > 34'h0FFFFFFFF) ? 32'hFFFFFFFF : fsum[31:0];
        ev_ok       = (tokens_reg >= 32'(eff_window)) && (end_raw < 32'(MAX_TOKENS));
        is_sink     = (sink_used_reg < eff_sinks);
        is_window   = (window_used_reg < eff_window);
        head_fix    = (ring_head_reg >= eff_window) ? 11'd0 : ring_head_reg;
        head_inc    = ((head_fix + 11'd1) >= eff_window) ? 11'd0 : (head_fix + 11'd1);
        ins_ok      = (32'(heavy_used_reg) < 32'(eff_heavy));
        rep_ok      = (ev_sc_reg > ms_reg);
        ring_res    = '{ACT_RING, tokens_reg, ring_slot_reg, 32'd0, new_sc_reg, held_reg};
        wait_res    = '{ACT_WAIT, ev_id_reg, 10'(waiting_used_reg), 32'd0, ev_sc_reg,
                        held_reg};
        flush_res   = '{ACT_FLUSH, 32'd0, 10'd0, blocks_reg, 32'd0, held_reg};
        cur_res     = rbuf_reg[ridx_reg];
        last        = ({1'b0, ridx_reg} == (rcnt_reg - 3'd1));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == (TOK_LIM - TC_W'(1)))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req.valid)
                    state_next = req.mode ? S_FB_RD : S_AP_RD;
            end
            S_FB_RD:    state_next = S_FB_CALC;
            S_FB_CALC:
            begin
                state_next = (in_rng_reg && (heavy_used_reg != '0)) ? S_FB_SCAN : S_EMIT;
            end
            S_FB_SCAN:
            begin
                if (!h_issue && !pend_reg)
                    state_next = S_EMIT;
            end
            S_AP_RD:    state_next = S_AP_DEC;
            S_AP_DEC:   state_next = (is_sink || is_window) ? S_EMIT : S_EV_RD;
            S_EV_RD:    state_next = S_EV_GET;
            S_EV_GET:   state_next = S_THR;
            S_THR:
            begin
                if (!thr_le && refresh_due && span_ok)
                    state_next = S_KTH_SCAN;
                else
                    state_next = S_ROUTE;
            end
            S_KTH_SCAN:
            begin
                if (!kth_issue && !pend_reg)
                    state_next = S_KTH_STEP;
            end
            S_KTH_STEP: state_next = (lo_n >= hi_n) ? S_ROUTE : S_KTH_SCAN;
            S_ROUTE:
            begin
                if ((ev_sc_reg >= held_reg) && !ins_ok)
                    state_next = S_MIN_SCAN;
                else
                    state_next = S_EMIT;
            end
            S_MIN_SCAN:
            begin
                if (!h_issue && !pend_reg)
                    state_next = S_MIN_DONE;
            end
            S_MIN_DONE: state_next = S_EMIT;
            S_EMIT:
            begin
                if (rsp.ready && last)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // memory controls and handshake outputs
    always_comb
    begin
        s_we    = 1'b0;
        s_waddr = tok_reg[TA_W-1:0];
        s_wdata = fb_res;
        s_re    = 1'b0;
        s_raddr = tok_reg[TA_W-1:0];
        h_we    = 1'b0;
        h_we_sc = 1'b0;
        h_waddr = heavy_used_reg[HA_W-1:0];
        h_wid   = ev_id_reg;
        h_wsc   = ev_sc_reg;
        h_re    = 1'b0;
        h_raddr = hscan_reg[HA_W-1:0];
        case (state_reg)
            S_CLEAR:
            begin
                s_we    = 1'b1;
                s_waddr = clr_cnt_reg[TA_W-1:0];
                s_wdata = 32'd0;
            end
            S_FB_RD:    s_re = in_rng_reg;
            S_FB_CALC:  s_we = in_rng_reg;
            S_FB_SCAN:
            begin
                h_re    = h_issue;
                h_waddr = hpaddr_reg;
                h_wsc   = new_sc_reg;
                h_we_sc = pend_reg && (h_rid == tok_reg);
            end
            S_AP_RD:
            begin
                s_re    = in_rng_reg;
                s_raddr = tokens_reg[TA_W-1:0];
            end
            S_EV_RD:
            begin
                s_re    = in_rng_reg;
                s_raddr = ev_id_reg[TA_W-1:0];
            end
            S_KTH_SCAN:
            begin
                s_re    = kth_issue;
                s_raddr = scan_reg[TA_W-1:0];
            end
            S_ROUTE:
            begin
                h_we    = (ev_sc_reg >= held_reg) && ins_ok;
                h_we_sc = (ev_sc_reg >= held_reg) && ins_ok;
            end
            S_MIN_SCAN: h_re = h_issue;
            S_MIN_DONE:
            begin
                h_waddr = mi_reg;
                h_we    = rep_ok;
                h_we_sc = rep_ok;
            end
            default:
            begin
                s_we = 1'b0;
            end
        endcase
        req.ready          = (state_reg == S_IDLE);
        rsp.valid          = (state_reg == S_EMIT);
        rsp.action         = cur_res.action;
        rsp.token_ref      = cur_res.token_ref;
        rsp.slot_index     = cur_res.slot_index;
        rsp.block_number   = cur_res.block_number;
        rsp.token_score    = cur_res.token_score;
        rsp.threshold_used = cur_res.threshold_used;
        rsp.last           = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_slots_reg   <= 7'd4;
            window_slots_reg <= 11'd64;
            heavy_cap_reg    <= 9'd64;
            heavy_ratio_reg  <= 17'd6554;
            decay_reg        <= 17'd62259;
            refresh_reg      <= 16'd16;
            block_sel_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SINK_SLOTS:   sink_slots_reg   <= cfg_data[6:0];
                CFG_WINDOW_SLOTS: window_slots_reg <= cfg_data[10:0];
                CFG_HEAVY_CAP:    heavy_cap_reg    <= cfg_data[8:0];
                CFG_HEAVY_RATIO:  heavy_ratio_reg  <= cfg_data;
                CFG_DECAY:        decay_reg        <= cfg_data;
                CFG_REFRESH:      refresh_reg      <= cfg_data[15:0];
                CFG_BLOCK_SEL:    block_sel_reg    <= cfg_data[0];
                default:          block_sel_reg    <= block_sel_reg;
            endcase
        end
    end

    // sequencer datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg      <= '0;
            sink_used_reg    <= '0;
            window_used_reg  <= '0;
            ring_head_reg    <= '0;
            heavy_used_reg   <= '0;
            waiting_used_reg <= '0;
            blocks_reg       <= '0;
            tokens_reg       <= '0;
            held_reg         <= '0;
            stamp_valid_reg  <= 1'b0;
            stamp_reg        <= '0;
            pend_reg         <= 1'b0;
            rcnt_reg         <= 3'd1;
            ridx_reg         <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + TC_W'(1);
                end
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        tok_reg    <= req.fb_token;
                        wgt_reg    <= req.fb_weight;
                        in_rng_reg <= req.mode ? (req.fb_token < 32'(MAX_TOKENS))
                                               : (tokens_reg < 32'(MAX_TOKENS));
                    end
                end
                S_FB_CALC:
                begin
                    rbuf_reg[0] <= '{ACT_SCORE, tok_reg, 10'd0, 32'd0,
                                     in_rng_reg ? fb_res : 32'd0, 32'd0};
                    new_sc_reg  <= fb_res;
                    rcnt_reg    <= 3'd1;
                    ridx_reg    <= '0;
                    hscan_reg   <= '0;
                    pend_reg    <= 1'b0;
                end
                S_FB_SCAN, S_MIN_SCAN:
                begin
                    if (h_issue)
                        hscan_reg <= hscan_reg + HU_W'(1);
                    pend_reg   <= h_issue;
                    hpaddr_reg <= hscan_reg[HA_W-1:0];
                    if ((state_reg == S_MIN_SCAN) && pend_reg &&
                        (mfirst_reg || (h_rsc < ms_reg)))
                    begin
                        ms_reg     <= h_rsc;
                        mid_reg    <= h_rid;
                        mi_reg     <= hpaddr_reg;
                        mfirst_reg <= 1'b0;
                    end
                end
                S_AP_DEC:
                begin
                    rcnt_reg <= 3'd1;
                    ridx_reg <= '0;
                    if (is_sink)
                    begin
                        rbuf_reg[0]   <= '{ACT_SINK, tokens_reg, 10'(sink_used_reg), 32'd0,
                                           in_rng_reg ? s_rdata : 32'd0, 32'd0};
                        sink_used_reg <= sink_used_reg + 7'd1;
                        tokens_reg    <= tokens_reg + 32'd1;
                    end
                    else if (is_window)
                    begin
                        rbuf_reg[0]     <= '{ACT_WINDOW, tokens_reg, window_used_reg[9:0],
                                             32'd0, in_rng_reg ? s_rdata : 32'd0, 32'd0};
                        window_used_reg <= window_used_reg + 11'd1;
                        tokens_reg      <= tokens_reg + 32'd1;
                    end
                    else
                    begin
                        ring_slot_reg <= head_fix[9:0];
                        ring_head_reg <= head_inc;
                        new_sc_reg    <= in_rng_reg ? s_rdata : 32'd0;
                        ev_id_reg     <= end_raw;
                        in_rng_reg    <= ev_ok;
                    end
                end
                S_EV_GET:
                begin
                    ev_sc_reg <= in_rng_reg ? s_rdata : 32'd0;
                end
                S_THR:
                begin
                    if (thr_le)
                    begin
                        held_reg <= '0;
                    end
                    else if (refresh_due)
                    begin
                        stamp_valid_reg <= 1'b1;
                        stamp_reg       <= tokens_reg;
                        if (span_ok)
                        begin
                            lo_reg   <= '0;
                            hi_reg   <= 32'hFFFFFFFF;
                            k_reg    <= kprod[16 +: TC_W];
                            cnt_reg  <= '0;
                            scan_reg <= TC_W'(eff_sinks);
                            end_reg  <= end_c;
                            pend_reg <= 1'b0;
                        end
                        else
                        begin
                            held_reg <= '0;
                        end
                    end
                end
                S_KTH_SCAN:
                begin
                    if (kth_issue)
                        scan_reg <= scan_reg + TC_W'(1);
                    pend_reg <= kth_issue;
                    if (pend_reg && (s_rdata <= mid))
                        cnt_reg <= cnt_reg + TC_W'(1);
                end
                S_KTH_STEP:
                begin
                    lo_reg   <= lo_n;
                    hi_reg   <= hi_n;
                    cnt_reg  <= '0;
                    scan_reg <= TC_W'(eff_sinks);
                    pend_reg <= 1'b0;
                    if (lo_n >= hi_n)
                        held_reg <= lo_n;
                end
                S_ROUTE:
                begin
                    ridx_reg    <= '0;
                    rbuf_reg[0] <= ring_res;
                    hscan_reg   <= '0;
                    pend_reg    <= 1'b0;
                    mfirst_reg  <= 1'b1;
                    if ((ev_sc_reg >= held_reg) && ins_ok)
                    begin
                        rbuf_reg[1]    <= '{ACT_HEAVY_INS, ev_id_reg, 10'(heavy_used_reg),
                                            32'd0, ev_sc_reg, held_reg};
                        rcnt_reg       <= 3'd2;
                        heavy_used_reg <= heavy_used_reg + HU_W'(1);
                        tokens_reg     <= tokens_reg + 32'd1;
                    end
                    else if (ev_sc_reg < held_reg)
                    begin
                        rbuf_reg[1]      <= wait_res;
                        rbuf_reg[2]      <= flush_res;
                        rcnt_reg         <= flush ? 3'd3 : 3'd2;
                        waiting_used_reg <= flush ? 6'd0 : wnext;
                        if (flush)
                            blocks_reg <= blocks_reg + 32'd1;
                        tokens_reg <= tokens_reg + 32'd1;
                    end
                end
                S_MIN_DONE:
                begin
                    ridx_reg         <= '0;
                    tokens_reg       <= tokens_reg + 32'd1;
                    waiting_used_reg <= flush ? 6'd0 : wnext;
                    if (flush)
                        blocks_reg <= blocks_reg + 32'd1;
                    if (rep_ok)
                    begin
                        rbuf_reg[1] <= '{ACT_DEMOTE, mid_reg, 10'(waiting_used_reg), 32'd0,
                                         ms_reg, held_reg};
                        rbuf_reg[2] <= '{ACT_HEAVY_REP, ev_id_reg, 10'(mi_reg), 32'd0,
                                         ev_sc_reg, held_reg};
                        rbuf_reg[3] <= flush_res;
                        rcnt_reg    <= flush ? 3'd4 : 3'd3;
                    end
                    else
                    begin
                        rbuf_reg[1] <= wait_res;
                        rbuf_reg[2] <= flush_res;
                        rcnt_reg    <= flush ? 3'd3 : 3'd2;
                    end
                end
                S_EMIT:
                begin
                    if (rsp.ready)
                        ridx_reg <= ridx_reg + 2'd1;
                end
                default:
                begin
                    pend_reg <= 1'b0;
                end
            endcase
        end
    end
endmodule

@@ hdl/kvtp_ram.sv @@
// ----------------------------------------------------------------------------
// kvtp_ram
// simple dual port ram, one write and one registered read
// ----------------------------------------------------------------------------
module kvtp_ram #(
    parameter int DEPTH = 256,
    parameter int DW    = 32,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench of the kv token tier placement unit: a clocked driver
// sends append and score feedback requests from a pending queue in random
// bursts, a placement model predicts every action, and a clocked monitor
// compares the actions the unit returns under a random stall pattern
// ----------------------------------------------------------------------------
module testbench;
    import kvtp_pkg::*;

    localparam int NTOK  = 4096;
    localparam int NHVY  = 256;
    localparam int NWIN  = 1024;
    localparam int NSINK = 64;

    typedef struct {
        logic        mode;
        logic [31:0] tok;
        logic [16:0] wgt;
    } request_t;

    typedef struct {
        result_t r;
        logic    last;
    } action_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;

    kvtp_req_if req ();
    kvtp_rsp_if rsp ();

    kv_token_tier_placement_unit dut (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    request_t pend_q[$];
    action_t  action_q[$];
    int       errors;
    int       n_sent;
    int       n_checked;
    int       n_flush;
    int       gen_seen;

    // placement model state
    logic [6:0]  m_sink;
    logic [10:0] m_win;
    logic [8:0]  m_hcap;
    logic [16:0] m_ratio;
    logic [16:0] m_decay;
    logic [15:0] m_refresh;
    logic        m_sel;
    logic [31:0] score_mem [NTOK];
    logic [31:0] hvy_id [NHVY];
    logic [31:0] hvy_sc [NHVY];
    int unsigned sink_used, win_used, ring_head, hvy_used, wait_used;
    logic [31:0] blk_cnt, seen, held_thr, stamp;
    bit          stamp_ok;
    action_t     step_out[4];
    int          step_n;

    function automatic int unsigned eff_sinks();
        return (m_sink > NSINK) ? NSINK : m_sink;
    endfunction

    function automatic int unsigned eff_win();
        if (m_win < 1) return 1;
        return (m_win > NWIN) ? NWIN : m_win;
    endfunction

    function automatic int unsigned eff_heavy();
        if (m_hcap < 1) return 1;
        return (m_hcap > NHVY) ? NHVY : m_hcap;
    endfunction

    function automatic logic [31:0] score_of(logic [31:0] id);
        return (id < NTOK) ? score_mem[id] : 32'd0;
    endfunction

    task automatic put(logic [3:0] act, logic [31:0] tok, int unsigned slot,
                       logic [31:0] blk, logic [31:0] sc, logic [31:0] thr);
        action_t a;
        a.r.action = act;
        a.r.token_ref = tok;
        a.r.slot_index = slot[9:0];
        a.r.block_number = blk;
        a.r.token_score = sc;
        a.r.threshold_used = thr;
        a.last = 1'b0;
        step_out[step_n] = a;
        step_n++;
    endtask

    function automatic logic [31:0] kth_score(int unsigned lo_i, int unsigned hi_i,
                                              longint unsigned k);
        longint unsigned lo, hi, mid, cnt;
        lo = 0;
        hi = 64'hFFFF_FFFF;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            cnt = 0;
            for (int unsigned i = lo_i; i < hi_i; i++)
                if (score_mem[i] <= mid) cnt++;
            if (cnt > k) hi = mid;
            else lo = mid + 1;
        end
        return lo[31:0];
    endfunction

    task automatic heavy_threshold(output logic [31:0] thr);
        longint st, en;
        longint unsigned n, r, q, k;
        st = eff_sinks();
        en = longint'(seen) - longint'(eff_win());
        if (en <= st) begin
            held_thr = 0;
            thr = 0;
            return;
        end
        if (!stamp_ok || (seen - stamp) >= {16'd0, m_refresh}) begin
            if (en > NTOK) en = NTOK;
            if (en <= st) held_thr = 0;
            else begin
                n = en - st;
                r = (m_ratio > 17'h10000) ? 64'h10000 : m_ratio;
                q = 64'h10000 - r;
                k = (q * (n - 1)) >> 16;
                held_thr = kth_score(st, en, k);
            end
            stamp_ok = 1;
            stamp = seen;
        end
        thr = held_thr;
    endtask

    task automatic add_waiting(logic [3:0] act, logic [31:0] tok, logic [31:0] sc,
                               logic [31:0] thr);
        put(act, tok, wait_used, 0, sc, thr);
        wait_used = (wait_used + 1) & 6'h3F;
        if (wait_used >= (m_sel ? 32 : 16)) begin
            put(ACT_FLUSH, 0, 0, blk_cnt, 0, thr);
            blk_cnt++;
            wait_used = 0;
        end
    endtask

    task automatic route_evicted();
        logic [31:0] id, sc, thr, ms, old_id, old_sc;
        int unsigned w, mi;
        w = eff_win();
        id = seen - w;
        sc = (seen < w) ? 32'd0 : score_of(id);
        heavy_threshold(thr);
        if (sc >= thr) begin
            if (hvy_used < eff_heavy()) begin
                hvy_id[hvy_used] = id;
                hvy_sc[hvy_used] = sc;
                put(ACT_HEAVY_INS, id, hvy_used, 0, sc, thr);
                hvy_used++;
                return;
            end
            mi = 0;
            ms = hvy_sc[0];
            for (int unsigned i = 1; i < hvy_used && i < NHVY; i++)
                if (hvy_sc[i] < ms) begin
                    ms = hvy_sc[i];
                    mi = i;
                end
            if (sc > ms) begin
                old_id = hvy_id[mi];
                old_sc = hvy_sc[mi];
                put(ACT_DEMOTE, old_id, wait_used, 0, old_sc, thr);
                wait_used = (wait_used + 1) & 6'h3F;
                hvy_id[mi] = id;
                hvy_sc[mi] = sc;
                put(ACT_HEAVY_REP, id, mi, 0, sc, thr);
                if (wait_used >= (m_sel ? 32 : 16)) begin
                    put(ACT_FLUSH, 0, 0, blk_cnt, 0, thr);
                    blk_cnt++;
                    wait_used = 0;
                end
                return;
            end
        end
        add_waiting(ACT_WAIT, id, sc, thr);
    endtask

    task automatic predict_placement(request_t it);
        longint unsigned d, v;
        logic [31:0] res, sc, id;
        int unsigned w, slot;
        step_n = 0;
        if (it.mode) begin
            res = 0;
            if (it.tok < NTOK) begin
                d = (m_decay > 17'h10000) ? 64'h10000 : m_decay;
                v = ((d * score_mem[it.tok]) >> 16) + it.wgt;
                if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
                res = v[31:0];
                score_mem[it.tok] = res;
                for (int unsigned i = 0; i < hvy_used && i < NHVY; i++)
                    if (hvy_id[i] == it.tok) hvy_sc[i] = res;
            end
            put(ACT_SCORE, it.tok, 0, 0, res, 0);
        end else begin
            w = eff_win();
            id = seen;
            sc = score_of(id);
            if (sink_used < eff_sinks()) begin
                put(ACT_SINK, id, sink_used, 0, sc, 0);
                sink_used++;
            end else if (win_used < w) begin
                put(ACT_WINDOW, id, win_used, 0, sc, 0);
                win_used++;
            end else begin
                if (ring_head >= w) ring_head = 0;
                slot = ring_head;
                ring_head = (ring_head + 1 >= w) ? 0 : ring_head + 1;
                put(ACT_RING, id, slot, 0, sc, 0);
                route_evicted();
                step_out[0].r.threshold_used = held_thr;
            end
            seen++;
        end
        step_out[step_n-1].last = 1'b1;
        for (int i = 0; i < step_n; i++) action_q.insert(action_q.size(), step_out[i]);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [16:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_SINK_SLOTS:   m_sink = val[6:0];
            CFG_WINDOW_SLOTS: m_win = val[10:0];
            CFG_HEAVY_CAP:    m_hcap = val[8:0];
            CFG_HEAVY_RATIO:  m_ratio = val;
            CFG_DECAY:        m_decay = val;
            CFG_REFRESH:      m_refresh = val[15:0];
            CFG_BLOCK_SEL:    m_sel = val[0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (!(pend_q.size() == 0 && action_q.size() == 0 && !req.valid))
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_all(logic [16:0] s, logic [16:0] w, logic [16:0] h,
                           logic [16:0] r, logic [16:0] d, logic [16:0] f,
                           logic [16:0] b);
        wait_drained();
        write_reg(CFG_SINK_SLOTS, s);
        write_reg(CFG_WINDOW_SLOTS, w);
        write_reg(CFG_HEAVY_CAP, h);
        write_reg(CFG_HEAVY_RATIO, r);
        write_reg(CFG_DECAY, d);
        write_reg(CFG_REFRESH, f);
        write_reg(CFG_BLOCK_SEL, b);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_req(logic m, logic [31:0] tok, logic [16:0] wgt);
        request_t it;
        it.mode = m;
        it.tok = tok;
        it.wgt = wgt;
        pend_q.insert(pend_q.size(), it);
        if (!m) gen_seen++;
    endtask

    task automatic queue_random();
        int unsigned r;
        logic [31:0] tok;
        logic [16:0] wgt;
        r = $urandom_range(0, 9);
        case ($urandom_range(0, 5))
            0: wgt = 17'h10000;
            1: wgt = 0;
            default: wgt = $urandom_range(0, 65536);
        endcase
        if (r < 6) queue_req(1'b0, $urandom, $urandom_range(0, 65536));
        else begin
            if (r == 9) tok = $urandom;
            else if (r == 8) tok = $urandom_range(NTOK - 2, NTOK + 1);
            else tok = $urandom_range(0, gen_seen + 2);
            queue_req(1'b1, tok, wgt);
        end
    endtask

    always begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // driver
    request_t cur;
    int       burst_left;
    int       gap_left;

    always @(posedge clk) begin
        if (req.valid && req.ready) begin
            predict_placement(cur);
            n_sent++;
        end
        if (!req.valid || req.ready) begin
            if (gap_left > 0) begin
                gap_left--;
                req.valid <= 1'b0;
            end else if (pend_q.size() > 0) begin
                cur = pend_q.pop_front();
                req.valid <= 1'b1;
                req.mode <= cur.mode;
                req.fb_token <= cur.tok;
                req.fb_weight <= cur.wgt;
                if (burst_left > 0) burst_left--;
                else begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else req.valid <= 1'b0;
        end
    end

    // monitor
    int      rdy_left;
    int      rdy_mode;
    action_t want;

    always @(posedge clk) begin
        if (rsp.valid && rsp.ready) begin
            if (action_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected action %0d token %0d", rsp.action, rsp.token_ref);
            end else begin
                want = action_q.pop_front();
                n_checked++;
                if (rsp.action == ACT_FLUSH) n_flush++;
                if (rsp.action !== want.r.action || rsp.token_ref !== want.r.token_ref ||
                    rsp.slot_index !== want.r.slot_index ||
                    rsp.block_number !== want.r.block_number ||
                    rsp.token_score !== want.r.token_score ||
                    rsp.threshold_used !== want.r.threshold_used ||
                    rsp.last !== want.last) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch exp act %0d tok %0d slot %0d blk %0d sc %h thr %h last %b",
                                 want.r.action, want.r.token_ref, want.r.slot_index,
                                 want.r.block_number, want.r.token_score,
                                 want.r.threshold_used, want.last);
                        $display("         got act %0d tok %0d slot %0d blk %0d sc %h thr %h last %b",
                                 rsp.action, rsp.token_ref, rsp.slot_index,
                                 rsp.block_number, rsp.token_score,
                                 rsp.threshold_used, rsp.last);
                    end
                end
            end
        end
        if (rdy_left == 0) begin
            rdy_mode = $urandom_range(0, 3);
            rdy_left = (rdy_mode == 1) ? $urandom_range(1, 6) : $urandom_range(1, 30);
        end else rdy_left--;
        case (rdy_mode)
            1: rsp.ready <= 1'b0;
            2: rsp.ready <= $urandom_range(0, 1);
            default: rsp.ready <= 1'b1;
        endcase
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SINK_SLOTS;
        cfg_data = 0;
        req.valid = 1'b0;
        req.mode = 1'b0;
        req.fb_token = 0;
        req.fb_weight = 0;
        rsp.ready = 1'b0;
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_flush = 0;
        gen_seen = 0;
        burst_left = 0;
        gap_left = 0;
        rdy_left = 0;
        rdy_mode = 0;
        m_sink = 4;
        m_win = 64;
        m_hcap = 64;
        m_ratio = 6554;
        m_decay = 62259;
        m_refresh = 16;
        m_sel = 0;
        for (int i = 0; i < NTOK; i++) score_mem[i] = 0;
        for (int i = 0; i < NHVY; i++) begin
            hvy_id[i] = 0;
            hvy_sc[i] = 0;
        end
        sink_used = 0;
        win_used = 0;
        ring_head = 0;
        hvy_used = 0;
        wait_used = 0;
        blk_cnt = 0;
        seen = 0;
        held_thr = 0;
        stamp = 0;
        stamp_ok = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes at reset settings
        queue_req(1'b1, 0, 17'h10000);
        queue_req(1'b1, 0, 0);
        queue_req(1'b1, NTOK - 1, 17'h10000);
        queue_req(1'b1, NTOK, 17'h10000);
        queue_req(1'b1, 32'hFFFF_FFFF, 17'h1FFFF & 17'h10000);
        queue_req(1'b1, 32'h5555_5555, 17'h0FFFF);
        for (int i = 0; i < 6; i++) queue_req(1'b0, 32'hFFFF_FFFF, 17'h10000);
        queue_req(1'b1, 5, 17'h0AAAA);
        queue_req(1'b1, 4, 17'h05555);

        // repeated full-weight feedback with no decay
        set_all(4, 64, 64, 6554, 17'h10000, 16, 0);
        for (int i = 0; i < 20; i++) queue_req(1'b1, 2, 17'h10000);

        // tight tiers: evictions, heavy insert, replace, demote and flushes
        set_all(0, 1, 1, 0, 0, 1, 0);
        for (int i = 0; i < 40; i++) queue_random();
        set_all(64, 3, 256, 17'h10000, 17'h10000, 16'hFFFF, 1);
        for (int i = 0; i < 30; i++) queue_random();
        set_all(17'h7F, 0, 0, 17'h1FFFF, 17'h1FFFF, 0, 0);
        for (int i = 0; i < 40; i++) queue_random();
        set_all(2, 17'h7FF, 17'h1FF, 32768, 40000, 3, 1);
        for (int i = 0; i < 15; i++) queue_random();
        for (int p = 0; p < 4; p++) begin
            set_all($urandom_range(0, 6), $urandom_range(1, 8), $urandom_range(1, 5),
                    $urandom_range(0, 65536), $urandom_range(0, 65536),
                    $urandom_range(0, 6), $urandom_range(0, 1));
            for (int i = 0; i < 25; i++) queue_random();
        end

        while (!(pend_q.size() == 0 && action_q.size() == 0 && !req.valid))
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("sent %0d requests, checked %0d actions, %0d block flushes",
                 n_sent, n_checked, n_flush);
        $display("covered ten register sets, out-of-range values and tight tier sizes");
        if (errors == 0 && action_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
